[src/lcpbm_pkg.sv]
// shared types and constants for the latched chr / prg bank mapper
`timescale 1ns / 1ps

package lcpbm_pkg;

  localparam logic [8:0] MAX_PRG_BANKS = 9'd16;

  localparam logic REQ_READ  = 1'b0;
  localparam logic REQ_WRITE = 1'b1;

  localparam logic [1:0] TGT_NONE = 2'd0;
  localparam logic [1:0] TGT_CHR  = 2'd1;
  localparam logic [1:0] TGT_PRG  = 2'd2;
  localparam logic [1:0] TGT_SRAM = 2'd3;

  typedef struct packed {
    logic        req_type;
    logic [15:0] address;
    logic [7:0]  write_data;
  } in_item_t;

  typedef struct packed {
    logic [1:0]  target;
    logic [21:0] mem_index;
    logic        write_enable;
    logic        mirror_horizontal;
  } out_item_t;

  // status from the bank register file to the sequencer
  typedef struct packed {
    logic       prg_div;
    logic [8:0] eff_count;
  } map_stat_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_EXEC,
    ST_DIV,
    ST_SEND
  } seq_state_t;

endpackage

[src/lcpbm_mod_unit.sv]
// restoring remainder unit: 8-bit dividend modulo 9-bit divisor, one bit per cycle
`timescale 1ns / 1ps

module lcpbm_mod_unit (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       start,
  input  logic [7:0] dividend,
  input  logic [8:0] divisor,
  output logic       done,
  output logic [7:0] rem
);

  logic [7:0] rem_r, rem_nxt;
  logic [7:0] dvd_r;
  logic [8:0] div_r;
  logic [2:0] cnt_r;
  logic       busy_r;
  logic       done_r;
  logic [8:0] trial;
  logic [8:0] diff;

  always_comb begin
    trial = {rem_r, dvd_r[7]};
    diff  = trial - div_r;
    // remainder stays below divisor, so it always fits in 8 bits
    if (trial >= div_r) begin
      rem_nxt = diff[7:0];
    end else begin
      rem_nxt = trial[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= '0;
      end else if (busy_r) begin
        cnt_r <= cnt_r + 3'd1;
        if (cnt_r == 3'd7) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      dvd_r <= dividend;
      div_r <= divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      dvd_r <= {dvd_r[6:0], 1'b0};
    end
  end

  assign done = done_r;
  assign rem  = rem_r;

endmodule

[src/lcpbm_map.sv]
// bank registers, latch logic and address translation of the mapper
`timescale 1ns / 1ps

module lcpbm_map (
  input  logic                 clk,
  input  logic                 rst_n,
  input  lcpbm_pkg::in_item_t  item,
  input  logic                 commit,
  input  logic                 prg_we,
  input  logic [7:0]           prg_val,
  input  logic                 cfg_we,
  input  logic [8:0]           cfg_val,
  output lcpbm_pkg::out_item_t res,
  output lcpbm_pkg::map_stat_t stat
);

  localparam logic [8:0] MAX_PRG_BANKS_C = lcpbm_pkg::MAX_PRG_BANKS;

  localparam logic [8:0] TILE_LO_FD = 9'h0FD;
  localparam logic [8:0] TILE_LO_FE = 9'h0FE;
  localparam logic [8:0] TILE_HI_FD = 9'h1FD;
  localparam logic [8:0] TILE_HI_FE = 9'h1FE;

  localparam logic [3:0] REG_PRG    = 4'hA;
  localparam logic [3:0] REG_CHR0   = 4'hB;
  localparam logic [3:0] REG_CHR1   = 4'hC;
  localparam logic [3:0] REG_CHR2   = 4'hD;
  localparam logic [3:0] REG_CHR3   = 4'hE;
  localparam logic [3:0] REG_MIRROR = 4'hF;

  logic       latch_low_r, latch_low_nxt;
  logic       latch_high_r, latch_high_nxt;
  logic [7:0] chr_sel_r [4];
  logic [7:0] chr_sel_nxt [4];
  logic [7:0] bank_low_r, bank_low_nxt;
  logic [7:0] bank_high_r, bank_high_nxt;
  logic [7:0] prg_bank_r;
  logic       mirror_r, mirror_nxt;
  logic [8:0] count_r;
  logic [8:0] eff_count;
  logic [8:0] last_full;
  logic [7:0] last_bank;
  logic [15:0] a;
  logic [7:0]  d;
  logic [8:0]  tile;

  // a count of 0 acts as 1, above 256 as 256
  always_comb begin
    if (count_r == 9'd0) begin
      eff_count = 9'd1;
    end else if (count_r > 9'd256) begin
      eff_count = 9'd256;
    end else begin
      eff_count = count_r;
    end
    last_full = eff_count - 9'd1;
    last_bank = last_full[7:0];
  end

  always_comb begin
    a    = item.address;
    d    = item.write_data;
    tile = a[12:4];

    latch_low_nxt  = latch_low_r;
    latch_high_nxt = latch_high_r;
    chr_sel_nxt    = chr_sel_r;
    bank_low_nxt   = bank_low_r;
    bank_high_nxt  = bank_high_r;
    mirror_nxt     = mirror_r;
    res            = '0;
    stat.prg_div   = 1'b0;

    if (item.req_type == lcpbm_pkg::REQ_READ) begin
      // latch flips before the same read is translated
      if (tile == TILE_LO_FD && latch_low_r) begin
        latch_low_nxt = 1'b0;
        bank_low_nxt  = chr_sel_r[0];
      end else if (tile == TILE_LO_FE && !latch_low_r) begin
        latch_low_nxt = 1'b1;
        bank_low_nxt  = chr_sel_r[1];
      end else if (tile == TILE_HI_FD && latch_high_r) begin
        latch_high_nxt = 1'b0;
        bank_high_nxt  = chr_sel_r[2];
      end else if (tile == TILE_HI_FE && !latch_high_r) begin
        latch_high_nxt = 1'b1;
        bank_high_nxt  = chr_sel_r[3];
      end

      if (a < 16'h1000) begin
        res.target    = lcpbm_pkg::TGT_CHR;
        res.mem_index = {2'b00, bank_low_nxt, a[11:0]};
      end else if (a < 16'h2000) begin
        res.target    = lcpbm_pkg::TGT_CHR;
        res.mem_index = {2'b00, bank_high_nxt, a[11:0]};
      end else if (a >= 16'hC000) begin
        res.target    = lcpbm_pkg::TGT_PRG;
        res.mem_index = {last_bank, a[13:0]};
      end else if (a >= 16'h8000) begin
        res.target    = lcpbm_pkg::TGT_PRG;
        res.mem_index = {prg_bank_r, a[13:0]};
      end else if (a >= 16'h6000) begin
        res.target    = lcpbm_pkg::TGT_SRAM;
        res.mem_index = {9'd0, a[12:0]};
      end
    end else begin
      if (a < 16'h2000) begin
        // chr writes bypass banking
        res.target       = lcpbm_pkg::TGT_CHR;
        res.mem_index    = {9'd0, a[12:0]};
        res.write_enable = 1'b1;
      end else if (a >= 16'h8000) begin
        case (a[15:12])
          REG_PRG: begin
            stat.prg_div = 1'b1;
          end
          REG_CHR0: begin
            chr_sel_nxt[0] = d;
            if (!latch_low_r) bank_low_nxt = d;
          end
          REG_CHR1: begin
            chr_sel_nxt[1] = d;
            if (latch_low_r) bank_low_nxt = d;
          end
          REG_CHR2: begin
            chr_sel_nxt[2] = d;
            if (!latch_high_r) bank_high_nxt = d;
          end
          REG_CHR3: begin
            chr_sel_nxt[3] = d;
            if (latch_high_r) bank_high_nxt = d;
          end
          REG_MIRROR: begin
            mirror_nxt = d[0];
          end
          default: begin
          end
        endcase
      end else if (a >= 16'h6000) begin
        res.target       = lcpbm_pkg::TGT_SRAM;
        res.mem_index    = {9'd0, a[12:0]};
        res.write_enable = 1'b1;
      end
    end

    res.mirror_horizontal = mirror_nxt;
    stat.eff_count        = eff_count;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      latch_low_r  <= 1'b1;
      latch_high_r <= 1'b1;
      chr_sel_r[0] <= 8'd0;
      chr_sel_r[1] <= 8'd4;
      chr_sel_r[2] <= 8'd0;
      chr_sel_r[3] <= 8'd0;
      bank_low_r   <= '0;
      bank_high_r  <= '0;
      prg_bank_r   <= '0;
      mirror_r     <= 1'b0;
      count_r      <= MAX_PRG_BANKS_C;
    end else begin
      if (commit) begin
        latch_low_r  <= latch_low_nxt;
        latch_high_r <= latch_high_nxt;
        chr_sel_r    <= chr_sel_nxt;
        bank_low_r   <= bank_low_nxt;
        bank_high_r  <= bank_high_nxt;
        mirror_r     <= mirror_nxt;
      end
      if (prg_we) begin
        prg_bank_r <= prg_val;
      end
      if (cfg_we) begin
        count_r <= cfg_val;
      end
    end
  end

endmodule

[src/latched_chr_prg_bank_mapper.sv]
// top level of the latched chr / prg bank mapper
// One bus access per item: the block answers with the memory it reaches
// (none, CHR, PRG or save RAM), the byte index in that memory, a write enable
// and the current mirroring. Reads of tile rows 0xFD/0xFE flip the pattern
// latches before the read is translated; writes at 0xA000-0xFFFF load the bank
// and mirroring registers. Items are handled one at a time: the next is taken
// once the last result is in the output register; a PRG bank select write
// (0xA000-0xAFFF) also waits while a subtract-compare unit reduces the bank
// number modulo the bank count, one bit per cycle. The result waits in the
// output register while out_stall is high. The user must write prg_bank_count
// (cfg_valid/cfg_data) only while no item is in flight; not enforced here.
`timescale 1ns / 1ps

module latched_chr_prg_bank_mapper (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  lcpbm_pkg::in_item_t  in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output lcpbm_pkg::out_item_t out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [8:0]           cfg_data
);

  lcpbm_pkg::seq_state_t state_r, state_nxt;
  lcpbm_pkg::in_item_t   item_r;
  lcpbm_pkg::out_item_t  res_r;
  lcpbm_pkg::out_item_t  out_r;
  lcpbm_pkg::out_item_t  map_res;
  lcpbm_pkg::map_stat_t  map_stat;
  logic                  out_valid_r, out_valid_nxt;
  logic                  item_ld;
  logic                  commit;
  logic                  div_start;
  logic                  div_done;
  logic [7:0]            div_rem;
  logic                  out_ld;

  assign cfg_ready = 1'b1;

  lcpbm_map u_map (
    .clk     (clk),
    .rst_n   (rst_n),
    .item    (item_r),
    .commit  (commit),
    .prg_we  (div_done),
    .prg_val (div_rem),
    .cfg_we  (cfg_valid && cfg_ready),
    .cfg_val (cfg_data),
    .res     (map_res),
    .stat    (map_stat)
  );

  lcpbm_mod_unit u_mod (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (item_r.write_data),
    .divisor  (map_stat.eff_count),
    .done     (div_done),
    .rem      (div_rem)
  );

  always_comb begin
    state_nxt = state_r;
    item_ld   = 1'b0;
    commit    = 1'b0;
    div_start = 1'b0;
    out_ld    = 1'b0;
    in_stall  = 1'b1;
    case (state_r)
      lcpbm_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          item_ld   = 1'b1;
          state_nxt = lcpbm_pkg::ST_EXEC;
        end
      end
      lcpbm_pkg::ST_EXEC: begin
        commit = 1'b1;
        if (map_stat.prg_div) begin
          div_start = 1'b1;
          state_nxt = lcpbm_pkg::ST_DIV;
        end else begin
          state_nxt = lcpbm_pkg::ST_SEND;
        end
      end
      lcpbm_pkg::ST_DIV: begin
        if (div_done) begin
          state_nxt = lcpbm_pkg::ST_SEND;
        end
      end
      lcpbm_pkg::ST_SEND: begin
        if (!out_valid_r || !out_stall) begin
          out_ld    = 1'b1;
          state_nxt = lcpbm_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = lcpbm_pkg::ST_IDLE;
      end
    endcase

    if (out_ld) begin
      out_valid_nxt = 1'b1;
    end else if (out_stall) begin
      out_valid_nxt = out_valid_r;
    end else begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= lcpbm_pkg::ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (item_ld) item_r <= in_data;
    if (commit)  res_r  <= map_res;
    if (out_ld)  out_r  <= res_r;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

[src/lcpbm_chk.sv]
// port-level checks for the mapper, bound to the top level
`timescale 1ns / 1ps

module lcpbm_chk (
  input logic                 clk,
  input logic                 rst_n,
  input logic                 in_valid,
  input logic                 in_stall,
  input logic                 out_valid,
  input logic                 out_stall,
  input lcpbm_pkg::out_item_t out_data
);

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed");

  // one item in flight: stall rises right after an accept
  a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> in_stall)
    else $error("second item accepted while busy");

  // writes only reach chr or save ram
  a_we_target: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.write_enable |->
      out_data.target == lcpbm_pkg::TGT_CHR || out_data.target == lcpbm_pkg::TGT_SRAM)
    else $error("write enable on wrong target");

  // unmapped results carry a zero index
  a_none_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.target == lcpbm_pkg::TGT_NONE |->
      out_data.mem_index == 22'd0 && !out_data.write_enable)
    else $error("unmapped result with nonzero index");

  // reset empties the output
  a_reset_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind latched_chr_prg_bank_mapper lcpbm_chk u_lcpbm_chk (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[bench/latched_chr_prg_bank_mapper_tb.sv]
// self-checking testbench for the latched chr / prg bank mapper
`timescale 1ns / 1ps

module latched_chr_prg_bank_mapper_tb;

  localparam int HOLD_CYCLES  = 80;
  localparam int WATCHDOG     = 1000;
  localparam int DRAIN_CYCLES = 20;
  localparam int PHASE_ITEMS  = 155;
  localparam int NUM_DIRECTED = 25;

  // short names for the directed table
  localparam logic       RD     = lcpbm_pkg::REQ_READ;
  localparam logic       WR     = lcpbm_pkg::REQ_WRITE;
  localparam logic [1:0] T_NONE = lcpbm_pkg::TGT_NONE;
  localparam logic [1:0] T_CHR  = lcpbm_pkg::TGT_CHR;
  localparam logic [1:0] T_PRG  = lcpbm_pkg::TGT_PRG;
  localparam logic [1:0] T_SRAM = lcpbm_pkg::TGT_SRAM;

  // latch tags: address bits 12..4
  localparam logic [15:0] TAG_MASK  = 16'h1FF0;
  localparam logic [15:0] TAG_LO_FD = 16'h0FD0;
  localparam logic [15:0] TAG_LO_FE = 16'h0FE0;
  localparam logic [15:0] TAG_HI_FD = 16'h1FD0;
  localparam logic [15:0] TAG_HI_FE = 16'h1FE0;

  // register pages for writes at 0xA000 and up
  localparam logic [3:0] PAGE_PRG_SEL = 4'hA;
  localparam logic [3:0] PAGE_CHR0    = 4'hB;
  localparam logic [3:0] PAGE_CHR1    = 4'hC;
  localparam logic [3:0] PAGE_CHR2    = 4'hD;
  localparam logic [3:0] PAGE_CHR3    = 4'hE;
  localparam logic [3:0] PAGE_MIRROR  = 4'hF;

  typedef struct packed {
    logic                 typed;
    lcpbm_pkg::in_item_t  item;
    lcpbm_pkg::out_item_t res;
  } dir_row_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  lcpbm_pkg::in_item_t  in_data;
  logic                 out_valid;
  logic                 out_stall;
  lcpbm_pkg::out_item_t out_data;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [8:0]           cfg_data;

  // typed expectation travelling alongside the current item
  logic                 row_typed;
  lcpbm_pkg::out_item_t row_res;

  // mapper state mirror
  logic [8:0] bank_count;
  logic       lat_lo, lat_hi;
  logic [7:0] chr_sel [4];
  logic [7:0] bank_lo, bank_hi, prg_sw;
  logic       mirror;

  lcpbm_pkg::out_item_t pending_q[$];
  dir_row_t             dir_rows [NUM_DIRECTED];

  int  errors = 0, n_items = 0, n_checked = 0, n_cfg = 0, n_flips = 0, n_holds = 0;
  int  idle_cnt;
  bit  quiet, hold_req, hold_done;

  latched_chr_prg_bank_mapper DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_data (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  function automatic int unsigned eff_banks();
    int unsigned c;
    c = 32'(bank_count);
    if (c == 0) c = 1;
    if (c > 256) c = 256;
    return c;
  endfunction

  function automatic void reset_mapper();
    bank_count = lcpbm_pkg::MAX_PRG_BANKS;
    lat_lo = 1'b1;
    lat_hi = 1'b1;
    chr_sel[0] = 8'd0;
    chr_sel[1] = 8'd4;
    chr_sel[2] = 8'd0;
    chr_sel[3] = 8'd0;
    bank_lo = 8'd0;
    bank_hi = 8'd0;
    prg_sw = 8'd0;
    mirror = 1'b0;
  endfunction

  // translates one bus access and updates the mirrored mapper state
  function automatic lcpbm_pkg::out_item_t map_access(lcpbm_pkg::in_item_t it);
    lcpbm_pkg::out_item_t r;
    logic [15:0] a;
    logic [7:0]  d;
    int unsigned c;
    r = '0;
    a = it.address;
    d = it.write_data;
    c = eff_banks();
    if (it.req_type == lcpbm_pkg::REQ_READ) begin
      // latch flips come before the translation of the same read
      case (a & TAG_MASK)
        TAG_LO_FD: if (lat_lo) begin
          lat_lo = 1'b0; bank_lo = chr_sel[0]; n_flips++;
        end
        TAG_LO_FE: if (!lat_lo) begin
          lat_lo = 1'b1; bank_lo = chr_sel[1]; n_flips++;
        end
        TAG_HI_FD: if (lat_hi) begin
          lat_hi = 1'b0; bank_hi = chr_sel[2]; n_flips++;
        end
        TAG_HI_FE: if (!lat_hi) begin
          lat_hi = 1'b1; bank_hi = chr_sel[3]; n_flips++;
        end
        default: ;
      endcase
      if (a < 16'h1000) begin
        r.target = lcpbm_pkg::TGT_CHR;
        r.mem_index = {2'b0, bank_lo, a[11:0]};
      end else if (a < 16'h2000) begin
        r.target = lcpbm_pkg::TGT_CHR;
        r.mem_index = {2'b0, bank_hi, a[11:0]};
      end else if (a >= 16'hC000) begin
        r.target = lcpbm_pkg::TGT_PRG;
        r.mem_index = 22'((c - 1) * 32'h4000 + 32'(a - 16'hC000));
      end else if (a >= 16'h8000) begin
        r.target = lcpbm_pkg::TGT_PRG;
        r.mem_index = {prg_sw, a[13:0]};
      end else if (a >= 16'h6000) begin
        r.target = lcpbm_pkg::TGT_SRAM;
        r.mem_index = 22'(a - 16'h6000);
      end
    end else begin
      if (a < 16'h2000) begin
        r.target = lcpbm_pkg::TGT_CHR;
        r.mem_index = 22'(a);
        r.write_enable = 1'b1;
      end else if (a >= 16'h8000) begin
        case (a[15:12])
          PAGE_PRG_SEL: prg_sw = 8'(int'(d) % c);
          PAGE_CHR0: begin
            chr_sel[0] = d;
            if (!lat_lo) bank_lo = d;
          end
          PAGE_CHR1: begin
            chr_sel[1] = d;
            if (lat_lo) bank_lo = d;
          end
          PAGE_CHR2: begin
            chr_sel[2] = d;
            if (!lat_hi) bank_hi = d;
          end
          PAGE_CHR3: begin
            chr_sel[3] = d;
            if (lat_hi) bank_hi = d;
          end
          PAGE_MIRROR: mirror = d[0];
          default: ;
        endcase
      end else if (a >= 16'h6000) begin
        r.target = lcpbm_pkg::TGT_SRAM;
        r.mem_index = 22'(a - 16'h6000);
        r.write_enable = 1'b1;
      end
    end
    r.mirror_horizontal = mirror;
    return r;
  endfunction

  // prediction and checking on accepted items
  always @(posedge clk) begin
    lcpbm_pkg::out_item_t want;
    bit                   moved;
    moved = 1'b0;
    if (!rst_n) begin
      reset_mapper();
      pending_q.delete();
      idle_cnt = 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        bank_count = cfg_data;
        n_cfg++;
        moved = 1'b1;
      end
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        if (pending_q.size() == 0) begin
          errors++;
          if (errors <= 10)
            $display("unexpected result: tgt=%0d idx=%h we=%b mir=%b", out_data.target,
                     out_data.mem_index, out_data.write_enable, out_data.mirror_horizontal);
        end else begin
          want = pending_q.pop_front();
          n_checked++;
          if (out_data.target !== want.target || out_data.mem_index !== want.mem_index ||
              out_data.write_enable !== want.write_enable ||
              out_data.mirror_horizontal !== want.mirror_horizontal) begin
            errors++;
            if (errors <= 10)
              $display("result %0d: want %0d/%h/%b/%b got %0d/%h/%b/%b (tgt/idx/we/mir)",
                       n_checked, want.target, want.mem_index, want.write_enable,
                       want.mirror_horizontal, out_data.target, out_data.mem_index,
                       out_data.write_enable, out_data.mirror_horizontal);
          end
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        n_items++;
        want = map_access(in_data);
        pending_q.push_back(row_typed ? row_res : want);
      end
      idle_cnt = moved ? 0 : idle_cnt + 1;
      if (idle_cnt >= WATCHDOG) begin
        $display("watchdog: no item moved for %0d cycles", WATCHDOG);
        $display("FAILURE");
        $finish;
      end
    end
  end

  // result side: random stall bursts plus one long hold-off
  initial begin
    out_stall = 1'b0;
    hold_done = 1'b0;
    wait (rst_n);
    @(posedge clk);
    forever begin
      if (hold_req && !hold_done) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_done = 1'b1;
        n_holds++;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 6)) @(posedge clk);
      end else begin
        out_stall <= 1'b0;
        repeat (quiet ? 1 : $urandom_range(1, 8)) @(posedge clk);
      end
    end
  end

  function automatic dir_row_t tbl_row(logic typed, logic rq, logic [15:0] a, logic [7:0] d,
                                       logic [1:0] tg, logic [21:0] ix, logic we, logic mh);
    dir_row_t r;
    r.typed = typed;
    r.item.req_type = rq;
    r.item.address = a;
    r.item.write_data = d;
    r.res.target = tg;
    r.res.mem_index = ix;
    r.res.write_enable = we;
    r.res.mirror_horizontal = mh;
    return r;
  endfunction

  // biased toward latch tags, bank register writes and mapped windows
  function automatic lcpbm_pkg::in_item_t rand_access();
    lcpbm_pkg::in_item_t it;
    int unsigned         pick;
    logic [15:0]         tag;
    it.req_type = lcpbm_pkg::REQ_READ;
    it.address = 16'($urandom);
    it.write_data = 8'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 15) begin
      case ($urandom_range(0, 3))
        0: tag = TAG_LO_FD;
        1: tag = TAG_LO_FE;
        2: tag = TAG_HI_FD;
        default: tag = TAG_HI_FE;
      endcase
      it.address = (($urandom_range(0, 1) ? it.address : 16'h0) & ~TAG_MASK) | tag;
    end else if (pick < 35) begin
      it.address = 16'($urandom_range(0, 16'h1FFF));
    end else if (pick < 50) begin
      it.req_type = lcpbm_pkg::REQ_WRITE;
      it.address[15:12] = 4'($urandom_range(PAGE_CHR0, PAGE_MIRROR));
    end else if (pick < 58) begin
      it.req_type = lcpbm_pkg::REQ_WRITE;
      it.address[15:12] = PAGE_PRG_SEL;
    end else if (pick < 73) begin
      it.address[15] = 1'b1;
    end else if (pick < 81) begin
      it.req_type = logic'($urandom_range(0, 1));
      it.address = 16'($urandom_range(16'h6000, 16'h7FFF));
    end else if (pick < 89) begin
      it.req_type = lcpbm_pkg::REQ_WRITE;
      it.address = 16'($urandom_range(0, 16'h1FFF));
    end else begin
      it.req_type = logic'($urandom_range(0, 1));
    end
    return it;
  endfunction

  task automatic send_access(lcpbm_pkg::in_item_t it, logic typed, lcpbm_pkg::out_item_t res);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    row_typed <= typed;
    row_res <= res;
    do @(posedge clk); while (!(in_valid && !in_stall));
  endtask

  // only while no item is in flight
  task automatic set_bank_count(logic [8:0] v);
    // first let the last accepted item get queued
    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!(cfg_valid && cfg_ready));
    cfg_valid <= 1'b0;
  endtask

  initial begin
    logic [8:0] counts [9];
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_valid = 1'b0;
    cfg_data = '0;
    row_typed = 1'b0;
    row_res = '0;
    quiet = 1'b0;
    hold_req = 1'b0;

    counts = '{9'd1, 9'd256, 9'd0, 9'd511, 9'd3, 9'd257, 9'd200,
               9'($urandom_range(2, 255)), 9'd16};

    // reset state: latches in FE, banks 0, count 16
    dir_rows[0]  = tbl_row(1'b1, RD, 16'h0000, 8'h00, T_CHR,  22'h0,     1'b0, 1'b0);
    dir_rows[1]  = tbl_row(1'b1, RD, 16'h1FFF, 8'hFF, T_CHR,  22'h00FFF, 1'b0, 1'b0);
    dir_rows[2]  = tbl_row(1'b1, RD, 16'hFFFF, 8'h00, T_PRG,  22'h3FFFF, 1'b0, 1'b0);
    dir_rows[3]  = tbl_row(1'b1, RD, 16'h8000, 8'h00, T_PRG,  22'h0,     1'b0, 1'b0);
    dir_rows[4]  = tbl_row(1'b1, RD, 16'h6000, 8'h00, T_SRAM, 22'h0,     1'b0, 1'b0);
    dir_rows[5]  = tbl_row(1'b1, RD, 16'h2000, 8'h00, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[6]  = tbl_row(1'b1, RD, 16'h5FFF, 8'h00, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[7]  = tbl_row(1'b1, WR, 16'h9FFF, 8'hFF, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[8]  = tbl_row(1'b1, WR, 16'h1FFF, 8'hAA, T_CHR,  22'h01FFF, 1'b1, 1'b0);
    dir_rows[9]  = tbl_row(1'b1, WR, 16'h7FFF, 8'h55, T_SRAM, 22'h01FFF, 1'b1, 1'b0);
    dir_rows[10] = tbl_row(1'b1, WR, 16'hB000, 8'h12, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[11] = tbl_row(1'b1, WR, 16'hC000, 8'h34, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[12] = tbl_row(1'b0, RD, 16'h0FE8, 8'h00, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[13] = tbl_row(1'b0, RD, 16'h0FD3, 8'h00, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[14] = tbl_row(1'b1, WR, 16'hD0FF, 8'hFF, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[15] = tbl_row(1'b1, WR, 16'hE000, 8'h80, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[16] = tbl_row(1'b0, RD, 16'h1FD0, 8'h00, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[17] = tbl_row(1'b0, RD, 16'h1FEF, 8'h00, T_NONE, 22'h0,     1'b0, 1'b0);
    // latch tag seen at a program address
    dir_rows[18] = tbl_row(1'b0, RD, 16'hEFE4, 8'h00, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[19] = tbl_row(1'b1, WR, 16'hA0FF, 8'hFF, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[20] = tbl_row(1'b0, RD, 16'hBFFF, 8'h00, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[21] = tbl_row(1'b1, WR, 16'hF000, 8'h01, T_NONE, 22'h0,     1'b0, 1'b1);
    dir_rows[22] = tbl_row(1'b0, RD, 16'h0000, 8'h00, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[23] = tbl_row(1'b1, WR, 16'hFFFF, 8'hFE, T_NONE, 22'h0,     1'b0, 1'b0);
    dir_rows[24] = tbl_row(1'b1, WR, 16'hA000, 8'h00, T_NONE, 22'h0,     1'b0, 1'b0);

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    repeat (2) @(posedge clk);

    foreach (dir_rows[i])
      send_access(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].res);
    in_valid <= 1'b0;

    for (int p = 0; p < 9; p++) begin
      set_bank_count(counts[p]);
      if (p == 1) hold_req = 1'b1;
      quiet = (p == 8);
      repeat (PHASE_ITEMS) send_access(rand_access(), 1'b0, '0);
      in_valid <= 1'b0;
    end

    @(posedge clk);
    while (pending_q.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("covered %0d accesses, %0d results checked, %0d latch flips", n_items, n_checked,
             n_flips);
    $display("bank count writes %0d (incl. 0, 1, 256, 257, 511), long hold-offs %0d", n_cfg,
             n_holds);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("%0d mismatches", errors);
      $display("FAILURE");
    end
    $finish;
  end

endmodule
